### hdl/tacc_pkg.sv
// Package for the 4x4 transform accumulator: sizes, command codes, sequencer
// states and the saturating helpers shared by the top level.
// Depends on nothing.
`default_nettype none

package tacc_pkg;

    localparam int ELEM_W        = 32;
    localparam int COEF_W        = 32;
    localparam int PROD_W        = ELEM_W + COEF_W;
    localparam int SUM_W         = PROD_W + 1;
    localparam int ROT_SHIFT     = 30;
    localparam int NUM_ELEMS     = 16;
    localparam int IDX_W         = 4;
    localparam int OP_W          = 3;
    localparam int DEF_FRAC_BITS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_IDENTITY  = 3'd0,
        OP_ROT_X     = 3'd1,
        OP_ROT_Y     = 3'd2,
        OP_ROT_Z     = 3'd3,
        OP_TRANSLATE = 3'd4,
        OP_READ      = 3'd5
    } opcode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IDENT,
        S_RD_A,
        S_RD_B,
        S_MUL_CA,
        S_MUL_SB,
        S_MUL_SA,
        S_MUL_CB,
        S_WR_Q,
        S_TR_RD,
        S_TR_WR,
        S_EL_RD,
        S_EL_DATA,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                     clamped;
        logic signed [ELEM_W-1:0] value;
    } sat_t;

    localparam logic signed [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic signed [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    // Floor shift of the exact rotation sum, then clamp to the element range.
    function automatic sat_t sat_rot(input logic signed [SUM_W-1:0] sum);
        logic [SUM_W-ROT_SHIFT-1:0] sh;
        sat_t                       res;
        sh = sum[SUM_W-1:ROT_SHIFT];
        if (!sh[SUM_W-ROT_SHIFT-1] && (|sh[SUM_W-ROT_SHIFT-2:ELEM_W-1])) begin
            res.clamped = 1'b1;
            res.value   = ELEM_MAX;
        end
        else if (sh[SUM_W-ROT_SHIFT-1] && !(&sh[SUM_W-ROT_SHIFT-2:ELEM_W-1])) begin
            res.clamped = 1'b1;
            res.value   = ELEM_MIN;
        end
        else begin
            res.clamped = 1'b0;
            res.value   = $signed(sh[ELEM_W-1:0]);
        end
        return res;
    endfunction

    // Clamp a sum of two elements that carries one extra bit.
    function automatic sat_t sat_add(input logic signed [ELEM_W:0] sum);
        sat_t res;
        if (sum[ELEM_W] != sum[ELEM_W-1]) begin
            res.clamped = 1'b1;
            res.value   = sum[ELEM_W] ? ELEM_MIN : ELEM_MAX;
        end
        else begin
            res.clamped = 1'b0;
            res.value   = $signed(sum[ELEM_W-1:0]);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hdl/tacc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module tacc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/transform_accumulator_4x4.sv
// Top level of the 4x4 transform accumulator: sequencer, shared multiplier
// and matrix storage. Depends on tacc_pkg and tacc_ram.
`default_nettype none

// The block holds a 4x4 homogeneous transform of signed fixed-point elements
// and applies one command per transfer: identity, rotation about X, Y or Z
// (cosine and sine given in Q2.30), translation of the last column, or a read
// of one element. Every command gives exactly one result. A rotation works
// through the columns one at a time, because one 32x32 multiplier is
// shared by all sixteen products and each column passes through two storage
// reads, four products and two writes. A translation passes each of the three
// rows through the storage port, a read and a write per row. The input is not
// ready while a command is in progress; a finished result waits in the output
// register while the next command is taken. Identity writes no storage: a
// valid bit per element marks what has been written since.
module transform_accumulator_4x4 #(
    parameter int ELEMENT_FRACTION_BITS = tacc_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic        [tacc_pkg::OP_W-1:0]    opcode,
    input  wire logic signed [tacc_pkg::COEF_W-1:0]  cos_value,
    input  wire logic signed [tacc_pkg::COEF_W-1:0]  sin_value,
    input  wire logic signed [tacc_pkg::ELEM_W-1:0]  delta_x,
    input  wire logic signed [tacc_pkg::ELEM_W-1:0]  delta_y,
    input  wire logic signed [tacc_pkg::ELEM_W-1:0]  delta_z,
    input  wire logic        [tacc_pkg::IDX_W-1:0]   element_index,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed      [tacc_pkg::ELEM_W-1:0]  read_value,
    output logic                                     saturated
);

    import tacc_pkg::*;

    localparam logic signed [ELEM_W-1:0] ONE_VAL = ELEM_W'(1) << ELEMENT_FRACTION_BITS;

    // Control registers.
    state_t                 state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    logic [NUM_ELEMS-1:0]   valid_reg, valid_next;
    logic [1:0]             cnt_reg, cnt_next;

    // Payload registers.
    logic [OP_W-1:0]           op_reg, op_next;
    logic signed [COEF_W-1:0]  cos_reg, cos_next;
    logic signed [COEF_W-1:0]  sin_reg, sin_next;
    logic signed [ELEM_W-1:0]  dx_reg, dx_next;
    logic signed [ELEM_W-1:0]  dy_reg, dy_next;
    logic signed [ELEM_W-1:0]  dz_reg, dz_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [1:0]                p_reg, p_next;
    logic [1:0]                q_reg, q_next;
    logic signed [ELEM_W-1:0]  a_reg, a_next;
    logic signed [ELEM_W-1:0]  b_reg, b_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  acc_reg, acc_next;
    logic signed [ELEM_W-1:0]  result_reg, result_next;
    logic                      sat_reg, sat_next;
    logic signed [ELEM_W-1:0]  read_value_reg, read_value_next;
    logic                      saturated_reg, saturated_next;
    logic                      rd_valid_reg;
    logic [IDX_W-1:0]          rd_addr_reg;

    // Storage port.
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ELEM_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ELEM_W-1:0]     ram_rdata;

    logic signed [ELEM_W-1:0]  rd_elem;
    logic signed [COEF_W-1:0]  mul_x;
    logic signed [ELEM_W-1:0]  mul_y;
    logic signed [SUM_W-1:0]   rot_sum;
    logic signed [ELEM_W:0]    tr_sum;
    logic signed [ELEM_W-1:0]  tr_delta;
    sat_t                      rot_res;
    sat_t                      tr_res;
    logic                      in_xfer;
    logic                      out_load;

    tacc_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (NUM_ELEMS)
    ) u_matrix (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // An element not written since the last identity reads as identity.
    assign rd_elem = rd_valid_reg ? $signed(ram_rdata)
                   : ((rd_addr_reg[3:2] == rd_addr_reg[1:0]) ? ONE_VAL : '0);

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // The one shared multiplier: operands chosen by the sequencer state.
    always_comb
    begin
        case (state_reg)
            S_MUL_CA: begin mul_x = cos_reg; mul_y = a_reg; end
            S_MUL_SB: begin mul_x = sin_reg; mul_y = b_reg; end
            S_MUL_SA: begin mul_x = sin_reg; mul_y = a_reg; end
            S_MUL_CB: begin mul_x = cos_reg; mul_y = b_reg; end
            default:  begin mul_x = cos_reg; mul_y = a_reg; end
        endcase
    end

    assign prod_next = PROD_W'(mul_x) * PROD_W'(mul_y);

    // New row p is c*a - s*b; new row q is s*a + c*b.
    assign rot_sum = (state_reg == S_MUL_SA)
                   ? (SUM_W'(acc_reg) - SUM_W'(prod_reg))
                   : (SUM_W'(acc_reg) + SUM_W'(prod_reg));
    assign rot_res = sat_rot(rot_sum);

    always_comb
    begin
        case (cnt_reg)
            2'd0:    tr_delta = dx_reg;
            2'd1:    tr_delta = dy_reg;
            default: tr_delta = dz_reg;
        endcase
    end

    assign tr_sum = (ELEM_W+1)'(rd_elem) + (ELEM_W+1)'(tr_delta);
    assign tr_res = sat_add(tr_sum);

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        cos_next        = cos_reg;
        sin_next        = sin_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        dz_next         = dz_reg;
        idx_next        = idx_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        acc_next        = acc_reg;
        result_next     = result_reg;
        sat_next        = sat_reg;
        read_value_next = read_value_reg;
        saturated_next  = saturated_reg;
        ram_we          = 1'b0;
        ram_waddr       = {p_reg, cnt_reg};
        ram_wdata       = rot_res.value;
        ram_raddr       = {p_reg, cnt_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next     = opcode;
                    cos_next    = cos_value;
                    sin_next    = sin_value;
                    dx_next     = delta_x;
                    dy_next     = delta_y;
                    dz_next     = delta_z;
                    idx_next    = element_index;
                    cnt_next    = 2'd0;
                    result_next = '0;
                    sat_next    = 1'b0;
                    case (opcode)
                        OP_IDENTITY:
                        begin
                            state_next = S_IDENT;
                        end
                        OP_ROT_X:
                        begin
                            p_next     = 2'd1;
                            q_next     = 2'd2;
                            state_next = S_RD_A;
                        end
                        OP_ROT_Y:
                        begin
                            p_next     = 2'd2;
                            q_next     = 2'd0;
                            state_next = S_RD_A;
                        end
                        OP_ROT_Z:
                        begin
                            p_next     = 2'd0;
                            q_next     = 2'd1;
                            state_next = S_RD_A;
                        end
                        OP_TRANSLATE:
                        begin
                            state_next = S_TR_RD;
                        end
                        OP_READ:
                        begin
                            state_next = S_EL_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_IDENT:
            begin
                valid_next = '0;
                state_next = S_DONE;
            end
            S_RD_A:
            begin
                ram_raddr  = {p_reg, cnt_reg};
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                ram_raddr  = {q_reg, cnt_reg};
                a_next     = rd_elem;
                state_next = S_MUL_CA;
            end
            S_MUL_CA:
            begin
                b_next     = rd_elem;
                state_next = S_MUL_SB;
            end
            S_MUL_SB:
            begin
                acc_next   = prod_reg;
                state_next = S_MUL_SA;
            end
            S_MUL_SA:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {p_reg, cnt_reg};
                ram_wdata  = rot_res.value;
                valid_next[{p_reg, cnt_reg}] = 1'b1;
                sat_next   = sat_reg | rot_res.clamped;
                state_next = S_MUL_CB;
            end
            S_MUL_CB:
            begin
                acc_next   = prod_reg;
                state_next = S_WR_Q;
            end
            S_WR_Q:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {q_reg, cnt_reg};
                ram_wdata  = rot_res.value;
                valid_next[{q_reg, cnt_reg}] = 1'b1;
                sat_next   = sat_reg | rot_res.clamped;
                cnt_next   = cnt_reg + 2'd1;
                state_next = (cnt_reg == 2'd3) ? S_DONE : S_RD_A;
            end
            S_TR_RD:
            begin
                ram_raddr  = {cnt_reg, 2'd3};
                state_next = S_TR_WR;
            end
            S_TR_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {cnt_reg, 2'd3};
                ram_wdata  = tr_res.value;
                valid_next[{cnt_reg, 2'd3}] = 1'b1;
                sat_next   = sat_reg | tr_res.clamped;
                cnt_next   = cnt_reg + 2'd1;
                state_next = (cnt_reg == 2'd2) ? S_DONE : S_TR_RD;
            end
            S_EL_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_EL_DATA;
            end
            S_EL_DATA:
            begin
                result_next = rd_elem;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    read_value_next = result_reg;
                    saturated_next  = sat_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        cos_reg        <= cos_next;
        sin_reg        <= sin_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        dz_reg         <= dz_next;
        idx_reg        <= idx_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        result_reg     <= result_next;
        sat_reg        <= sat_next;
        read_value_reg <= read_value_next;
        saturated_reg  <= saturated_next;
        rd_valid_reg   <= valid_reg[ram_raddr];
        rd_addr_reg    <= ram_raddr;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign saturated  = saturated_reg;

    // The storage is never written while waiting for a command.
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("matrix written while idle");

    // An identity command leaves every element reading as identity.
    a_ident_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDENT) |=> (valid_reg == '0))
        else $error("identity left written elements");

    // Only rotations and translations can report clamping.
    a_sat_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (!saturated || $past(op_reg == OP_ROT_X || op_reg == OP_ROT_Y
                                         || op_reg == OP_ROT_Z
                                         || op_reg == OP_TRANSLATE)))
        else $error("saturation reported for a command that updates nothing");

    // Only a read command returns a non-zero value.
    a_value_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> ((read_value == '0) || $past(op_reg == OP_READ)))
        else $error("non-zero value for a command other than read");

endmodule

`default_nettype wire

### tb/sv/tb_transform_accumulator_4x4.sv
// Self-checking testbench for transform_accumulator_4x4: bursty command driver, stalling
// result monitor and a cycle-free predictor of the 4x4 fixed-point transform.
// Depends on tacc_pkg and the transform_accumulator_4x4 RTL.
`default_nettype none

module tb_transform_accumulator_4x4;
    timeunit 1ns;
    timeprecision 1ps;

    import tacc_pkg::*;

    // Opcodes the block must accept and answer without touching the matrix.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    localparam logic signed [COEF_W-1:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [65:0]       WIDE_MAX = 66'sd2147483647;
    localparam logic signed [65:0]       WIDE_MIN = -66'sd2147483648;
    localparam int                       RANDOM_CMDS = 750;
    localparam int                       SETTLE_CYCLES = 40;
    localparam int                       HOLD_CYCLES = 600;
    localparam int                       HOLD_AFTER = 150;

    typedef struct {
        logic        [OP_W-1:0]   op;
        logic signed [COEF_W-1:0] cos_v;
        logic signed [COEF_W-1:0] sin_v;
        logic signed [ELEM_W-1:0] dx;
        logic signed [ELEM_W-1:0] dy;
        logic signed [ELEM_W-1:0] dz;
        logic        [IDX_W-1:0]  idx;
    } tx_cmd_t;

    typedef struct {
        logic                     clamped;
        logic signed [ELEM_W-1:0] value;
    } reading_t;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                     clk;
    logic                     rst_n         = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_ready;
    logic        [OP_W-1:0]   opcode        = '0;
    logic signed [COEF_W-1:0] cos_value     = '0;
    logic signed [COEF_W-1:0] sin_value     = '0;
    logic signed [ELEM_W-1:0] delta_x       = '0;
    logic signed [ELEM_W-1:0] delta_y       = '0;
    logic signed [ELEM_W-1:0] delta_z       = '0;
    logic        [IDX_W-1:0]  element_index = '0;
    logic                     out_valid;
    logic                     out_ready     = 1'b0;
    logic signed [ELEM_W-1:0] read_value;
    logic                     saturated;

    logic signed [ELEM_W-1:0] xform [NUM_ELEMS];
    tx_cmd_t                  cmd_queue[$];
    reading_t                 pending_results[$];
    int                       mismatch_count = 0;
    int                       results_seen = 0;
    int                       burst_left = 1;
    int                       gap_left = 0;
    int                       hold_left = 0;
    logic                     hold_used = 1'b0;
    rx_mode_t                 rx_mode = RX_STEADY;
    int                       rx_mode_left = 0;
    int                       rx_tick = 0;

    transform_accumulator_4x4 i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .cos_value     (cos_value),
        .sin_value     (sin_value),
        .delta_x       (delta_x),
        .delta_y       (delta_y),
        .delta_z       (delta_z),
        .element_index (element_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_value    (read_value),
        .saturated     (saturated)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic report_mismatch(input string what, input logic signed [ELEM_W-1:0] want,
                                   input logic signed [ELEM_W-1:0] got);
        if (mismatch_count < 100)
        begin
            $display("%0t ns: mismatch on %s, expected %0d got %0d", $time, what, want, got);
        end
        mismatch_count++;
    endtask

    function automatic reading_t clamp_wide(input logic signed [65:0] v);
        reading_t r;
        r.clamped = 1'b1;
        if (v > WIDE_MAX)
        begin
            r.value = ELEM_MAX;
        end
        else if (v < WIDE_MIN)
        begin
            r.value = ELEM_MIN;
        end
        else
        begin
            r.clamped = 1'b0;
            r.value   = v[ELEM_W-1:0];
        end
        return r;
    endfunction

    task automatic load_identity();
        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            xform[i] = (i % 5 == 0) ? (32'sd1 <<< DEF_FRAC_BITS) : '0;
        end
    endtask

    // Rows p and q become c*p - s*q and s*p + c*q; the sums are exact before the floor shift.
    task automatic rotate_rows(input int p, input int q, input logic signed [COEF_W-1:0] c,
                               input logic signed [COEF_W-1:0] s, inout logic hit);
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic signed [65:0]       ca;
        logic signed [65:0]       sb;
        logic signed [65:0]       sa;
        logic signed [65:0]       cb;
        logic signed [65:0]       mix;
        reading_t                 np;
        reading_t                 nq;
        for (int col = 0; col < 4; col++)
        begin
            a   = xform[p * 4 + col];
            b   = xform[q * 4 + col];
            ca  = c * a;
            sb  = s * b;
            sa  = s * a;
            cb  = c * b;
            mix = ca - sb;
            np  = clamp_wide(mix >>> ROT_SHIFT);
            mix = sa + cb;
            nq  = clamp_wide(mix >>> ROT_SHIFT);
            xform[p * 4 + col] = np.value;
            xform[q * 4 + col] = nq.value;
            hit = hit | np.clamped | nq.clamped;
        end
    endtask

    task automatic apply_command(input tx_cmd_t cmd);
        reading_t           res;
        reading_t           moved;
        logic signed [65:0] w;
        res.value   = '0;
        res.clamped = 1'b0;
        case (cmd.op)
            OP_IDENTITY: load_identity();
            OP_ROT_X:    rotate_rows(1, 2, cmd.cos_v, cmd.sin_v, res.clamped);
            OP_ROT_Y:    rotate_rows(2, 0, cmd.cos_v, cmd.sin_v, res.clamped);
            OP_ROT_Z:    rotate_rows(0, 1, cmd.cos_v, cmd.sin_v, res.clamped);
            OP_TRANSLATE:
            begin
                w = xform[3] + cmd.dx;
                moved = clamp_wide(w);
                xform[3] = moved.value;
                res.clamped |= moved.clamped;
                w = xform[7] + cmd.dy;
                moved = clamp_wide(w);
                xform[7] = moved.value;
                res.clamped |= moved.clamped;
                w = xform[11] + cmd.dz;
                moved = clamp_wide(w);
                xform[11] = moved.value;
                res.clamped |= moved.clamped;
            end
            OP_READ:     res.value = xform[cmd.idx];
            default:     ;
        endcase
        pending_results.push_back(res);
    endtask

    function automatic tx_cmd_t build_cmd(input logic [OP_W-1:0] op,
                                          input logic signed [COEF_W-1:0] c,
                                          input logic signed [COEF_W-1:0] s,
                                          input logic signed [ELEM_W-1:0] dx,
                                          input logic signed [ELEM_W-1:0] dy,
                                          input logic signed [ELEM_W-1:0] dz,
                                          input logic [IDX_W-1:0] idx);
        tx_cmd_t cmd;
        cmd.op    = op;
        cmd.cos_v = c;
        cmd.sin_v = s;
        cmd.dx    = dx;
        cmd.dy    = dy;
        cmd.dz    = dz;
        cmd.idx   = idx;
        return cmd;
    endfunction

    // Mostly modest offsets so that the matrix stays in range, now and then any value.
    function automatic logic signed [ELEM_W-1:0] pick_delta();
        logic signed [ELEM_W-1:0] d;
        d = $urandom;
        if ($urandom_range(0, 9) < 7)
        begin
            d = d >>> 10;
        end
        return d;
    endfunction

    // Sender: bursts of transfers separated by random gaps; valid holds until taken.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            logic send;
            if (in_valid && in_ready)
            begin
                apply_command(cmd_queue.pop_front());
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
                end
            end
            send = 1'b0;
            if (in_valid && !in_ready)
            begin
                send = 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (cmd_queue.size() > 0)
            begin
                send          = 1'b1;
                opcode        <= cmd_queue[0].op;
                cos_value     <= cmd_queue[0].cos_v;
                sin_value     <= cmd_queue[0].sin_v;
                delta_x       <= cmd_queue[0].dx;
                delta_y       <= cmd_queue[0].dy;
                delta_z       <= cmd_queue[0].dz;
                element_index <= cmd_queue[0].idx;
            end
            in_valid <= send;
        end
    end

    // Long hold-off on the result side once enough results have gone through, so that
    // the output register fills and the block stops taking commands.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_used && results_seen >= HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
    end

    // Receiver: checks each result transfer and stalls on a changing pattern.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            logic     take;
            reading_t want;
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result transfer with nothing expected", '0, read_value);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (read_value !== want.value)
                    begin
                        report_mismatch("read_value", want.value, read_value);
                    end
                    if (saturated !== want.clamped)
                    begin
                        report_mismatch("saturated", ELEM_W'(want.clamped), ELEM_W'(saturated));
                    end
                end
            end
            if (rx_mode_left == 0)
            begin
                rx_mode      = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(20, 200);
            end
            else
            begin
                rx_mode_left--;
            end
            rx_tick++;
            case (rx_mode)
                RX_STEADY:   take = 1'b1;
                RX_COIN:     take = 1'($urandom_range(0, 1));
                RX_SPARSE:   take = ($urandom_range(0, 3) == 0);
                RX_PERIODIC: take = (rx_tick % 5) < 2;
                default:     take = 1'b1;
            endcase
            out_ready <= take && (hold_left == 0);
        end
    end

    initial
    begin
        tx_cmd_t cmd;
        real     ang;
        int      pick;
        int      kind;

        load_identity();

        // Directed part: field extremes, every opcode and the clamping corners.
        cmd_queue.push_back(build_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd0));
        cmd_queue.push_back(build_cmd(OP_READ, '1, '1, '1, '1, '1, 4'd15));
        cmd_queue.push_back(build_cmd(OP_TRANSLATE, '0, '0, ELEM_MAX, ELEM_MIN, '1, 4'd0));
        // Pushes the last column past both ends of the element range.
        cmd_queue.push_back(build_cmd(OP_TRANSLATE, '0, '0, 32'sd1, '1, '0, 4'd0));
        cmd_queue.push_back(build_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd3));
        cmd_queue.push_back(build_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd7));
        cmd_queue.push_back(build_cmd(OP_SPARE_A, '1, '1, '1, '1, '1, '1));
        cmd_queue.push_back(build_cmd(OP_SPARE_B, '0, '0, '0, '0, '0, '0));
        cmd_queue.push_back(build_cmd(OP_ROT_Z, ELEM_MIN, ELEM_MIN, '0, '0, '0, 4'd0));
        cmd_queue.push_back(build_cmd(OP_IDENTITY, '1, '1, '1, '1, '1, '1));
        // With both elements at the most negative value and both coefficients too, the
        // second sum overflows 64 bits and must still clamp high.
        cmd_queue.push_back(build_cmd(OP_TRANSLATE, '0, '0, ELEM_MIN, ELEM_MIN, ELEM_MIN, 4'd0));
        cmd_queue.push_back(build_cmd(OP_ROT_Z, ELEM_MIN, ELEM_MIN, '0, '0, '0, 4'd0));
        cmd_queue.push_back(build_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd3));
        cmd_queue.push_back(build_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd7));
        cmd_queue.push_back(build_cmd(OP_IDENTITY, '0, '0, '0, '0, '0, '0));
        cmd_queue.push_back(build_cmd(OP_ROT_X, ONE_Q30, '0, '0, '0, '0, 4'd0));
        cmd_queue.push_back(build_cmd(OP_ROT_Y, '0, ONE_Q30, '0, '0, '0, 4'd0));
        // Coefficients just under two, well beyond one, are used as given.
        cmd_queue.push_back(build_cmd(OP_ROT_Z, ELEM_MAX, ELEM_MAX, '0, '0, '0, 4'd0));
        cmd_queue.push_back(build_cmd(OP_ROT_X, -ONE_Q30, -ONE_Q30, '0, '0, '0, 4'd0));
        cmd_queue.push_back(build_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd10));
        cmd_queue.push_back(build_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd5));
        cmd_queue.push_back(build_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd0));
        cmd_queue.push_back(build_cmd(OP_IDENTITY, '0, '0, '0, '0, '0, '0));
        cmd_queue.push_back(build_cmd(OP_READ, '0, '0, '0, '0, '0, 4'd12));

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            cmd = build_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                            IDX_W'($urandom_range(0, 15)));
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                cmd.op = OP_IDENTITY;
            end
            else if (pick < 45)
            begin
                cmd.op = (pick < 18) ? OP_ROT_X : (pick < 31) ? OP_ROT_Y : OP_ROT_Z;
                kind = $urandom_range(0, 9);
                if (kind < 6)
                begin
                    ang = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
                    cmd.cos_v = $rtoi($cos(ang) * 1073741824.0);
                    cmd.sin_v = $rtoi($sin(ang) * 1073741824.0);
                end
                else if (kind < 8)
                begin
                    cmd.cos_v = $urandom_range(0, 32'd2147483648) - 32'd1073741824;
                    cmd.sin_v = $urandom_range(0, 32'd2147483648) - 32'd1073741824;
                end
            end
            else if (pick < 65)
            begin
                cmd.op = OP_TRANSLATE;
                cmd.dx = pick_delta();
                cmd.dy = pick_delta();
                cmd.dz = pick_delta();
            end
            else if (pick >= 97)
            begin
                cmd.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
            end
            cmd_queue.push_back(cmd);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hdl/tacc_pkg.sv
hdl/tacc_ram.sv
hdl/transform_accumulator_4x4.sv
tb/sv/tb_transform_accumulator_4x4.sv
